// File: src/pih_pkg.sv
// shared types, constants and register indexes for the interarrival histogram
package pih_pkg;

  localparam int unsigned TIME_W      = 48;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned BIN_FIELD_W = 6;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned CFG_W       = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_SHIFT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_PERIOD = 2'd1;

  localparam logic [CNT_W-1:0] PERIOD_RESET = 32'd100000;

  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [TIME_W-1:0]      arrival_time;
    logic                   is_ipv4;
    logic [BIN_FIELD_W-1:0] read_bin;
  } in_word_t;

  typedef struct packed {
    logic                   kind;
    logic [CNT_W-1:0]       report_number;
    logic [CNT_W-1:0]       ipv4_total;
    logic [CNT_W-1:0]       skipped_periods;
    logic [BIN_FIELD_W-1:0] bin_number;
    logic [CNT_W-1:0]       bin_count;
    logic                   last;
  } out_word_t;

  // classified work handed from the front to the back
  typedef struct packed {
    logic                   is_read;
    logic                   has_bin;
    logic [BIN_FIELD_W-1:0] bin;
    logic                   is_ipv4;
    logic                   report;
    logic [CNT_W-1:0]       report_number;
    logic [CNT_W-1:0]       skipped_periods;
  } cmd_t;

endpackage

// File: src/packet_interarrival_histogram.sv
// top level of the packet interarrival histogram with interval reports
//
// input channel: a word is taken when push is high and full is low. an arrival
// word bins the gap to the previous packet into a cumulative and an interval
// histogram; a read word asks for one cumulative bin.
// result channel: the oldest result sits on out_word_o while empty is low and
// leaves when pop is high. a read gives one word, a report gives one word
// per bin, lowest bin first, last set on the top bin.
// config: cfg_we_i writes register cfg_idx_i (0 bin shift, 1 report period)
// in the same cycle; unknown indexes are dropped. write only while idle.
// throughput: in the back end an arrival is a bin read, then the write-back of
// both histogram rams; the front takes a new word every cycle while the 2-deep
// command queue has room. a report reads, then sends each bin in turn. when an
// arrival skips more than one period, the front runs a divider and holds full.
// a read answer passes the input register, the command queue, the ram read and
// then the result queue before it shows on out_word_o.
// reset clears the schedule, the counters and all bin valid bits, so both
// histograms read as zero. a stalled receiver fills the 2-deep result queue,
// then the back end, the command queue and finally full back up.
module packet_interarrival_histogram #(
  parameter int unsigned NUM_BINS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  pih_pkg::in_word_t             in_word_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output pih_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [pih_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pih_pkg::CFG_W-1:0]     cfg_data_i
);

  import pih_pkg::*;

  // configuration registers
  logic [SHIFT_W-1:0] bin_shift_q, bin_shift_d;
  logic [CNT_W-1:0]   period_q, period_d;

  // front to back command queue
  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  // back to result queue
  out_word_t res_in;
  logic      res_push, res_full;

  always_comb begin
    bin_shift_d = bin_shift_q;
    period_d    = period_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BIN_SHIFT:     bin_shift_d = cfg_data_i[SHIFT_W-1:0];
        REG_REPORT_PERIOD: period_d    = cfg_data_i[CNT_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_shift_q <= '0;
      period_q    <= PERIOD_RESET;
    end else begin
      bin_shift_q <= bin_shift_d;
      period_q    <= period_d;
    end
  end

  // front: bin position, deadline bookkeeping, skipped period count
  pih_front #(.NUM_BINS(NUM_BINS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_word_i   (in_word_i),
    .full_o      (full),
    .bin_shift_i (bin_shift_q),
    .period_i    (period_q),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  pih_fifo #(.DATA_T(cmd_t), .DEPTH(2)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  // back: histogram rams, ipv4 count, report walk
  pih_back #(.NUM_BINS(NUM_BINS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue decouples the walk from a stalling receiver
  pih_fifo #(.DATA_T(out_word_t), .DEPTH(2)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty)
  );

  // a read answer is a single word with no report context
  a_read_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.kind == KIND_READ) |->
    (out_word_o.last && out_word_o.report_number == '0 &&
     out_word_o.ipv4_total == '0 && out_word_o.skipped_periods == '0))
    else $error("read answer carries report fields or misses last");

  // a report run ends exactly on the top bin
  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.kind == KIND_REPORT) |->
    (out_word_o.last == (out_word_o.bin_number == BIN_FIELD_W'(NUM_BINS - 1))))
    else $error("report last flag not on the top bin");

  // report bins come out in order with nothing in between
  a_report_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && out_word_o.kind == KIND_REPORT && !out_word_o.last) |=>
    (empty || (out_word_o.kind == KIND_REPORT &&
               out_word_o.bin_number == $past(out_word_o.bin_number) + BIN_FIELD_W'(1))))
    else $error("report run interrupted or out of order");

endmodule

// File: src/pih_ram.sv
// generic one-write one-read ram with registered read data
module pih_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/pih_fifo.sv
// small register queue with full and empty flags
module pih_fifo #(
  parameter type DATA_T = logic,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  DATA_T data_i,
  output logic  full_o,
  input  logic  pop_i,
  output DATA_T data_o,
  output logic  empty_o
);

  DATA_T               mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_BITS'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/pih_div.sv
// restoring divider, one quotient bit per cycle
module pih_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pih_pkg::TIME_W-1:0] num_i,
  input  logic [pih_pkg::CNT_W-1:0]  den_i,
  output logic                       busy_o,
  output logic [pih_pkg::TIME_W-1:0] quot_o,
  output logic [pih_pkg::CNT_W-1:0]  rem_o
);

  import pih_pkg::*;

  localparam int unsigned STEP_W = $clog2(TIME_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TIME_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, quot_q[TIME_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(TIME_W);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quot_d = {quot_q[TIME_W-2:0], fits};
      rem_d  = fits ? CNT_W'(rem_sh - {1'b0, den_q}) : rem_sh[CNT_W-1:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: src/pih_front.sv
// front end: takes words, computes the bin and the report schedule
module pih_front #(
  parameter int unsigned NUM_BINS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  pih_pkg::in_word_t           in_word_i,
  output logic                        full_o,
  input  logic [pih_pkg::SHIFT_W-1:0] bin_shift_i,
  input  logic [pih_pkg::CNT_W-1:0]   period_i,
  output logic                        cmd_push_o,
  output pih_pkg::cmd_t               cmd_o,
  input  logic                        cmd_full_i
);

  import pih_pkg::*;

  localparam logic F_RUN = 1'b0;
  localparam logic F_DIV = 1'b1;

  logic              state_q, state_d;
  logic              in_valid_q, in_valid_d;
  in_word_t          in_q;
  logic [TIME_W-1:0] prev_time_q, prev_time_d;
  logic              have_prev_q, have_prev_d;
  logic [TIME_W-1:0] deadline_q, deadline_d;
  logic              armed_q, armed_d;
  logic [CNT_W-1:0]  rep_cnt_q, rep_cnt_d;

  logic [TIME_W-1:0]      t;
  logic [CNT_W-1:0]       period_eff;
  logic [TIME_W:0]        gap;
  logic [TIME_W-1:0]      gap_sh;
  logic [BIN_FIELD_W-1:0] pos;
  logic [TIME_W-1:0]      first_dl, next_dl, div_dl;
  logic                   late, need_div, done;
  logic                   div_start, div_busy;
  logic [TIME_W-1:0]      div_quot;
  logic [CNT_W-1:0]       div_rem;
  logic [TIME_W:0]        extra;
  logic [CNT_W-1:0]       skip_div;

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] v);
    return v[TIME_W] ? '1 : v[TIME_W-1:0];
  endfunction

  assign t          = in_q.arrival_time;
  assign period_eff = (period_i == '0) ? CNT_W'(1) : period_i;

  // bin position of the gap, negative gaps to bin zero, large ones to the top bin
  assign gap    = {1'b0, t} - {1'b0, prev_time_q};
  assign gap_sh = gap[TIME_W-1:0] >> bin_shift_i;
  always_comb begin
    if (gap[TIME_W]) begin
      pos = '0;
    end else if (gap_sh > TIME_W'(NUM_BINS - 1)) begin
      pos = BIN_FIELD_W'(NUM_BINS - 1);
    end else begin
      pos = gap_sh[BIN_FIELD_W-1:0];
    end
  end

  assign first_dl = sat_time({1'b0, t} + (TIME_W + 1)'(period_eff));
  assign next_dl  = sat_time({1'b0, deadline_q} + (TIME_W + 1)'(period_eff));
  assign late     = armed_q && (t > deadline_q);
  assign need_div = late && (t > next_dl);

  // several periods passed: the remainder places the new deadline without a multiply
  assign extra    = {1'b0, div_quot} + (TIME_W + 1)'(1);
  assign div_dl   = sat_time({1'b0, t} + (TIME_W + 1)'(period_eff - CNT_W'(1) - div_rem));
  assign skip_div = (|extra[TIME_W:CNT_W]) ? '1 : extra[CNT_W-1:0];

  pih_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t - next_dl - TIME_W'(1)),
    .den_i   (period_eff),
    .busy_o  (div_busy),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    in_valid_d  = in_valid_q;
    prev_time_d = prev_time_q;
    have_prev_d = have_prev_q;
    deadline_d  = deadline_q;
    armed_d     = armed_q;
    rep_cnt_d   = rep_cnt_q;
    div_start   = 1'b0;
    done        = 1'b0;

    cmd_o                 = '0;
    cmd_o.is_read         = (in_q.func == FUNC_READ);
    cmd_o.has_bin         = have_prev_q && (in_q.func == FUNC_ARRIVAL);
    cmd_o.bin             = (in_q.func == FUNC_READ) ? in_q.read_bin : pos;
    cmd_o.is_ipv4         = in_q.is_ipv4 && (in_q.func == FUNC_ARRIVAL);
    cmd_o.report          = late && (in_q.func == FUNC_ARRIVAL);
    cmd_o.report_number   = rep_cnt_q;
    cmd_o.skipped_periods = '0;

    if (in_valid_q) begin
      if (in_q.func == FUNC_READ) begin
        done = !cmd_full_i;
      end else if (state_q == F_DIV) begin
        if (!div_busy && !cmd_full_i) begin
          done                  = 1'b1;
          state_d               = F_RUN;
          deadline_d            = div_dl;
          rep_cnt_d             = rep_cnt_q + div_quot[CNT_W-1:0] + CNT_W'(2);
          cmd_o.skipped_periods = skip_div;
        end
      end else if (need_div) begin
        div_start = 1'b1;
        state_d   = F_DIV;
      end else begin
        done = !cmd_full_i;
        if (done) begin
          if (!armed_q) begin
            deadline_d = first_dl;
            armed_d    = 1'b1;
          end else if (late) begin
            deadline_d = next_dl;
            rep_cnt_d  = rep_cnt_q + CNT_W'(1);
          end
        end
      end
      if (done && (in_q.func == FUNC_ARRIVAL)) begin
        prev_time_d = t;
        have_prev_d = 1'b1;
      end
    end

    if (done) begin
      in_valid_d = 1'b0;
    end
    if (push_i && !full_o) begin
      in_valid_d = 1'b1;
    end
  end

  assign full_o     = in_valid_q && !done;
  assign cmd_push_o = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_RUN;
      in_valid_q  <= 1'b0;
      prev_time_q <= '0;
      have_prev_q <= 1'b0;
      deadline_q  <= '0;
      armed_q     <= 1'b0;
      rep_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      in_valid_q  <= in_valid_d;
      prev_time_q <= prev_time_d;
      have_prev_q <= have_prev_d;
      deadline_q  <= deadline_d;
      armed_q     <= armed_d;
      rep_cnt_q   <= rep_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      in_q <= in_word_i;
    end
  end

endmodule

// File: src/pih_back.sv
// back end: bin updates, cumulative reads and interval report walks
module pih_back #(
  parameter int unsigned NUM_BINS = 64,
  localparam int unsigned BIN_W = $clog2(NUM_BINS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_empty_i,
  input  pih_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output pih_pkg::out_word_t res_o
);

  import pih_pkg::*;

  localparam logic [2:0] B_IDLE    = 3'd0;
  localparam logic [2:0] B_UPD     = 3'd1;
  localparam logic [2:0] B_RD_RESP = 3'd2;
  localparam logic [2:0] B_REP_RD  = 3'd3;
  localparam logic [2:0] B_REP_WR  = 3'd4;

  logic [2:0]          state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [BIN_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    ipv4_cnt_q, ipv4_cnt_d;
  logic [NUM_BINS-1:0] cum_vld_q, cum_vld_d;
  logic [NUM_BINS-1:0] int_vld_q, int_vld_d;

  logic             cum_re, cum_we, int_re, int_we;
  logic [BIN_W-1:0] cum_raddr, int_raddr, upd_addr;
  logic [CNT_W-1:0] cum_rdata, int_rdata, cum_wdata, int_wdata;
  logic [CNT_W-1:0] cum_cur, int_cur;
  logic             bin_ok;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  assign upd_addr = cmd_q.bin[BIN_W-1:0];
  assign cum_cur  = cum_vld_q[upd_addr] ? cum_rdata : '0;
  assign int_cur  = int_vld_q[upd_addr] ? int_rdata : '0;
  assign bin_ok   = ({1'b0, cmd_q.bin} < (BIN_FIELD_W + 1)'(NUM_BINS));

  pih_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (cum_we),
    .waddr_i (upd_addr),
    .wdata_i (cum_wdata),
    .re_i    (cum_re),
    .raddr_i (cum_raddr),
    .rdata_o (cum_rdata)
  );

  pih_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_int_ram (
    .clk_i   (clk_i),
    .we_i    (int_we),
    .waddr_i (upd_addr),
    .wdata_i (int_wdata),
    .re_i    (int_re),
    .raddr_i (int_raddr),
    .rdata_o (int_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    ipv4_cnt_d = ipv4_cnt_q;
    cum_vld_d  = cum_vld_q;
    int_vld_d  = int_vld_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    cum_re     = 1'b0;
    int_re     = 1'b0;
    cum_we     = 1'b0;
    int_we     = 1'b0;
    cum_raddr  = cmd_i.bin[BIN_W-1:0];
    int_raddr  = cmd_i.bin[BIN_W-1:0];
    cum_wdata  = sat_inc(cum_cur);
    int_wdata  = sat_inc(int_cur);

    res_o                 = '0;
    res_o.kind            = KIND_REPORT;
    res_o.report_number   = cmd_q.report_number;
    res_o.ipv4_total      = ipv4_cnt_q;
    res_o.skipped_periods = cmd_q.skipped_periods;
    res_o.bin_number      = BIN_FIELD_W'(idx_q);
    res_o.bin_count       = int_vld_q[idx_q] ? int_rdata : '0;
    res_o.last            = (idx_q == BIN_W'(NUM_BINS - 1));

    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          cum_re    = 1'b1;
          if (cmd_i.is_read) begin
            state_d = B_RD_RESP;
          end else begin
            int_re  = cmd_i.has_bin;
            cum_re  = cmd_i.has_bin;
            state_d = B_UPD;
          end
        end
      end
      B_UPD: begin
        if (cmd_q.has_bin) begin
          cum_we              = 1'b1;
          int_we              = 1'b1;
          cum_vld_d[upd_addr] = 1'b1;
          int_vld_d[upd_addr] = 1'b1;
        end
        if (cmd_q.is_ipv4) begin
          ipv4_cnt_d = sat_inc(ipv4_cnt_q);
        end
        if (cmd_q.report) begin
          idx_d   = '0;
          state_d = B_REP_RD;
        end else begin
          state_d = B_IDLE;
        end
      end
      B_RD_RESP: begin
        res_o                 = '0;
        res_o.kind            = KIND_READ;
        res_o.bin_number      = cmd_q.bin;
        res_o.bin_count       = (bin_ok && cum_vld_q[upd_addr]) ? cum_rdata : '0;
        res_o.last            = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      B_REP_RD: begin
        int_re    = 1'b1;
        int_raddr = idx_q;
        state_d   = B_REP_WR;
      end
      B_REP_WR: begin
        if (!res_full_i) begin
          res_push_o       = 1'b1;
          int_vld_d[idx_q] = 1'b0;
          if (idx_q == BIN_W'(NUM_BINS - 1)) begin
            ipv4_cnt_d = '0;
            state_d    = B_IDLE;
          end else begin
            idx_d   = idx_q + BIN_W'(1);
            state_d = B_REP_RD;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      idx_q      <= '0;
      ipv4_cnt_q <= '0;
      cum_vld_q  <= '0;
      int_vld_q  <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      ipv4_cnt_q <= ipv4_cnt_d;
      cum_vld_q  <= cum_vld_d;
      int_vld_q  <= int_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: test/tb_top.sv
// self-checking testbench for the packet interarrival histogram
`timescale 1ns / 1ps

module tb_top;
  import pih_pkg::*;

  localparam int unsigned NUM_BINS       = 64;
  localparam int unsigned IDLE_PCT       = 23;    // chance in a hundred that a side idles
  localparam int unsigned HOLD_AT        = 90;    // words taken before the long receiver stall
  localparam int unsigned HOLD_LEN       = 400;   // length of that stall in cycles
  localparam int unsigned SETTLE_CYCLES  = 64;    // covers the divider and the bin write-back
  localparam int unsigned WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side

  // register index that the block has to drop
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;

  // dut connections; the inputs are known from time zero
  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 push       = 1'b0;
  in_word_t             in_word    = '0;
  logic                 full;
  logic                 empty;
  logic                 pop        = 1'b0;
  out_word_t            dut_result;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // words waiting to be pushed, and result words the histogram should give back
  in_word_t  pending_words[$];
  out_word_t expected_words[$];

  // predictor copy of the registers and of the block state
  logic [SHIFT_W-1:0] cfg_shift;
  logic [CNT_W-1:0]   cfg_period;
  logic [63:0]        last_arrival;
  logic               seen_arrival;
  logic [63:0]        next_deadline;
  logic               deadline_set;
  logic [CNT_W-1:0]   v4_count;
  logic [CNT_W-1:0]   interval_index;
  logic [CNT_W-1:0]   total_hist  [NUM_BINS];
  logic [CNT_W-1:0]   window_hist [NUM_BINS];

  // stimulus time base and bookkeeping
  logic [TIME_W-1:0] stamp = '0;
  out_word_t         result_want;
  bit                no_idle      = 1'b0;
  bit                hold_done    = 1'b0;
  int unsigned       hold_left    = 0;
  int unsigned       words_taken  = 0;
  int unsigned       results_seen = 0;
  int unsigned       reports_seen = 0;
  int unsigned       error_count  = 0;
  int unsigned       stall_cycles = 0;

  packet_interarrival_histogram #(
    .NUM_BINS(NUM_BINS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_word_i  (in_word),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (dut_result),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // counters stick at all ones
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // the deadline sticks at the top of the 48-bit time range
  function automatic logic [63:0] cap48(input logic [63:0] v);
    return (v > MAX48) ? MAX48 : v;
  endfunction

  // works out the result words that one accepted word causes
  task automatic predict_histogram(input in_word_t w);
    logic [63:0]      t;
    logic [63:0]      period;
    logic [63:0]      pos;
    logic [63:0]      extra;
    logic [63:0]      skip;
    logic [CNT_W-1:0] rep;
    logic [CNT_W-1:0] v4tot;
    out_word_t        r;
    begin
      r = '0;
      // read answer: one word straight from the cumulative histogram
      if (w.func == FUNC_READ) begin
        r.kind       = KIND_READ;
        r.bin_number = w.read_bin;
        r.bin_count  = total_hist[w.read_bin];
        r.last       = 1'b1;
        expected_words.push_back(r);
      end else begin
        t = {16'd0, w.arrival_time};
        // a zero period behaves as one tick
        period = (cfg_period == '0) ? 64'd1 : {32'd0, cfg_period};

        // bin the gap; an earlier arrival lands in bin 0, a long gap in the top bin
        if (seen_arrival) begin
          pos = 64'd0;
          if (t >= last_arrival)
            pos = (t - last_arrival) >> cfg_shift;
          if (pos > 64'(NUM_BINS - 1))
            pos = 64'(NUM_BINS - 1);
          total_hist[pos[5:0]]  = bump(total_hist[pos[5:0]]);
          window_hist[pos[5:0]] = bump(window_hist[pos[5:0]]);
        end
        last_arrival = t;
        seen_arrival = 1'b1;

        // the current packet is counted before any report it triggers
        if (w.is_ipv4)
          v4_count = bump(v4_count);

        if (!deadline_set) begin
          // first packet arms the schedule one period ahead
          next_deadline = cap48(t + period);
          deadline_set  = 1'b1;
        end else if (t > next_deadline) begin
          rep   = interval_index;
          v4tot = v4_count;
          extra = 64'd0;
          next_deadline = cap48(next_deadline + period);
          // whole periods that went by on this same packet
          if (t > next_deadline) begin
            extra         = (t - next_deadline - 64'd1) / period + 64'd1;
            next_deadline = cap48(next_deadline + extra * period);
          end
          skip = (extra > MAX32) ? MAX32 : extra;
          interval_index = interval_index + 32'd1 + extra[31:0];

          // one word per bin, lowest first, last on the top bin
          for (int i = 0; i < NUM_BINS; i++) begin
            r.kind            = KIND_REPORT;
            r.report_number   = rep;
            r.ipv4_total      = v4tot;
            r.skipped_periods = skip[31:0];
            r.bin_number      = i[5:0];
            r.bin_count       = window_hist[i];
            r.last            = (i == NUM_BINS - 1);
            expected_words.push_back(r);
            window_hist[i] = '0;
          end
          v4_count = '0;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the oldest pending word, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_histogram(in_word);
        void'(pending_words.pop_front());
        words_taken++;
      end
      if (pending_words.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        push    <= 1'b1;
        in_word <= pending_words[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes result words and checks them against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: kind %0d bin %0d count %0d",
                 dut_result.kind, dut_result.bin_number, dut_result.bin_count);
          error_count++;
        end else begin
          result_want = expected_words.pop_front();
          check_field("kind", 64'(result_want.kind), 64'(dut_result.kind));
          check_field("report_number", 64'(result_want.report_number),
                      64'(dut_result.report_number));
          check_field("ipv4_total", 64'(result_want.ipv4_total),
                      64'(dut_result.ipv4_total));
          check_field("skipped_periods", 64'(result_want.skipped_periods),
                      64'(dut_result.skipped_periods));
          check_field("bin_number", 64'(result_want.bin_number),
                      64'(dut_result.bin_number));
          check_field("bin_count", 64'(result_want.bin_count),
                      64'(dut_result.bin_count));
          check_field("last", 64'(result_want.last), 64'(dut_result.last));
          if (result_want.kind == KIND_REPORT && result_want.last)
            reports_seen++;
        end
      end

      // one long stall while the sender keeps pushing, so full has to back up
      if (!hold_done && words_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write, mirrored into the predictor; only called while idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BIN_SHIFT)
      cfg_shift = data[SHIFT_W-1:0];
    else if (idx == REG_REPORT_PERIOD)
      cfg_period = data;
  endtask

  // wait until every word is in and every result is out, then let the back end settle
  task automatic wait_for_quiet();
    while (pending_words.size() != 0 || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_arrival(input logic [TIME_W-1:0] t, input logic v4);
    in_word_t w;
    w              = '0;
    w.func         = FUNC_ARRIVAL;
    w.arrival_time = t;
    w.is_ipv4      = v4;
    w.read_bin     = BIN_FIELD_W'($urandom_range(0, 63));
    pending_words.push_back(w);
    stamp = t;
  endtask

  // unused fields of a read carry random bits
  task automatic queue_read(input logic [BIN_FIELD_W-1:0] bin);
    in_word_t w;
    w              = '0;
    w.func         = FUNC_READ;
    w.arrival_time = TIME_W'({$urandom, $urandom});
    w.is_ipv4      = 1'($urandom_range(0, 1));
    w.read_bin     = bin;
    pending_words.push_back(w);
  endtask

  // gap sized to the current bin width or report period
  function automatic logic [63:0] pick_gap();
    logic [63:0] per;
    logic [63:0] g;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    per = (cfg_period == '0) ? 64'd1 : {32'd0, cfg_period};
    if (sel < 60) begin
      // aim at a bin, a little past the top too, with random low bits
      g = {32'd0, $urandom_range(0, NUM_BINS + 2)} << cfg_shift;
      g = g | ({$urandom, $urandom} & ((64'd1 << cfg_shift) - 1));
    end else if (sel < 85) begin
      g = {32'd0, $urandom} % (per / 4 + 1);
    end else begin
      // cross one or more deadlines, sometimes skipping whole periods
      g = per * $urandom_range(1, 5) + {32'd0, $urandom} % per;
    end
    return g;
  endfunction

  // mostly a rising packet stream, some reads, some packets back in time;
  // wild mode throws timestamps anywhere in the 48-bit range
  task automatic queue_random_items(input int count, input bit wild);
    int unsigned sel;
    logic [63:0] step;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        queue_read(BIN_FIELD_W'($urandom_range(0, 63)));
      end else if (wild && sel < 55) begin
        queue_arrival(TIME_W'({$urandom, $urandom}), 1'($urandom_range(0, 1)));
      end else if (sel < 15) begin
        step = {32'd0, $urandom_range(1, 70)} << cfg_shift;
        queue_arrival(stamp - step[TIME_W-1:0], 1'($urandom_range(0, 1)));
      end else begin
        step = pick_gap();
        queue_arrival(stamp + step[TIME_W-1:0], 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // predictor starts from the reset state
    cfg_shift      = '0;
    cfg_period     = PERIOD_RESET;
    last_arrival   = '0;
    seen_arrival   = 1'b0;
    next_deadline  = '0;
    deadline_set   = 1'b0;
    v4_count       = '0;
    interval_index = '0;
    for (int i = 0; i < NUM_BINS; i++) begin
      total_hist[i]  = '0;
      window_hist[i] = '0;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on reset register values: shift 0, period 100000
    queue_read(6'd0);                // empty histogram, bottom bin
    queue_read(6'd63);               // empty histogram, top bin
    queue_arrival(48'd0, 1'b1);      // first packet at time zero arms the deadline
    queue_arrival(48'd5, 1'b0);      // gap 5
    queue_arrival(48'd3, 1'b1);      // earlier than the previous packet
    queue_arrival(48'd1003, 1'b0);   // gap far past the top bin
    queue_arrival(48'd1066, 1'b1);   // gap 63, exactly the top bin
    queue_arrival(48'd1128, 1'b0);   // gap 62
    queue_arrival(48'd100001, 1'b1); // just past the deadline, plain report
    queue_arrival(48'd450001, 1'b0); // two whole periods skipped
    queue_read(6'd5);
    queue_read(6'd62);
    queue_read(6'd63);
    queue_read(6'd0);
    wait_for_quiet();                // sender holds off until every result is back
    queue_random_items(55, 1'b0);
    wait_for_quiet();

    // medium bins, short period; the long receiver stall falls in here
    write_reg(REG_BIN_SHIFT, 32'd4);
    write_reg(REG_REPORT_PERIOD, 32'd3000);
    queue_random_items(95, 1'b0);
    wait_for_quiet();

    // widest bins and longest period, with no idling on either side
    write_reg(REG_BIN_SHIFT, 32'd31);
    write_reg(REG_REPORT_PERIOD, 32'hFFFF_FFFF);
    no_idle = 1'b1;
    queue_random_items(60, 1'b0);
    wait_for_quiet();
    no_idle = 1'b0;

    // zero period acts as one tick: almost every packet closes an interval
    write_reg(REG_BIN_SHIFT, 32'd2);
    write_reg(REG_REPORT_PERIOD, 32'd0);
    queue_random_items(30, 1'b0);
    wait_for_quiet();

    // period of one tick; huge jumps saturate the skip count and wrap the report number;
    // the spare index must not touch either register
    write_reg(REG_BIN_SHIFT, 32'd10);
    write_reg(REG_REPORT_PERIOD, 32'd1);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    queue_arrival(stamp + 48'h0100_0000_0000, 1'b1);
    queue_arrival(stamp + 48'h0002_0000_0005, 1'b0);
    queue_random_items(40, 1'b0);
    wait_for_quiet();

    // run the schedule into the top of the time range, where the deadline sticks
    write_reg(REG_BIN_SHIFT, 32'd20);
    write_reg(REG_REPORT_PERIOD, 32'd500);
    queue_arrival(48'hFFFF_FFFF_FF00, 1'b1);
    queue_arrival(48'hFFFF_FFFF_FFFF, 1'b1);
    queue_random_items(50, 1'b1);
    queue_read(6'd0);
    queue_read(6'd63);
    wait_for_quiet();

    $display("covered %0d words in and %0d result words out, %0d interval reports",
             words_taken, results_seen, reports_seen);
    $display("bin shift 0 to 31, report period 0, 1, 3000, 100000 and all ones");
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
src/pih_pkg.sv
src/pih_ram.sv
src/pih_fifo.sv
src/pih_div.sv
src/pih_front.sv
src/pih_back.sv
src/packet_interarrival_histogram.sv
test/tb_top.sv
